>>> sv/sps_pkg.sv
// Shared types, codes and helpers for the stepper phase sequencer.
// Used by sps_div and stepper_phase_sequencer_core; no dependencies.
package sps_pkg;

  // Field and datapath widths
  localparam int unsigned PHASE_PINS = 4;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned DIV_W      = 26;
  localparam int unsigned DVS_W      = 16;
  localparam int unsigned CNT_W      = $clog2(DIV_W);

  // Microseconds in one minute
  localparam logic [DIV_W-1:0] US_PER_MIN = DIV_W'(60000000);

  // Request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_MOVE = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPR   = 2'd0;
  localparam logic [1:0] CFG_SPEED = 2'd1;
  localparam logic [1:0] CFG_TABLE = 2'd2;

  // Configuration reset values (usual full-step sequence in the table)
  localparam logic [CFG_W-1:0] SPR_RST   = 16'd200;
  localparam logic [CFG_W-1:0] SPEED_RST = 16'd0;
  localparam logic [CFG_W-1:0] TABLE_RST = 16'h9A65;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] step_count;
  } sps_in_t;

  typedef struct packed {
    logic [PHASE_PINS-1:0] phase_pins;
    logic [POS_W-1:0]      position;
    logic                  busy_res;
    logic                  stepped;
  } sps_out_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } sps_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } sps_div_rsp_t;

  // Position after one step, wrapping at the revolution size
  function automatic logic [POS_W-1:0] sps_next_pos(input logic [POS_W-1:0] pos,
                                                    input logic [CFG_W-1:0] spr,
                                                    input logic rev);
    logic [POS_W-1:0] inc;
    logic             over;
    inc  = pos + POS_W'(1);
    over = (spr != '0) && (pos >= spr);
    if (!rev) begin
      if ((spr != '0) && (inc >= spr)) begin
        return '0;
      end
      return inc;
    end
    if ((pos == '0) || over) begin
      return spr - CFG_W'(1);
    end
    return pos - POS_W'(1);
  endfunction

  // Coil levels of the phase table row picked by position mod 4
  function automatic logic [PHASE_PINS-1:0] sps_row_pins(input logic [CFG_W-1:0] tbl,
                                                         input logic [1:0] row);
    logic [CFG_W-1:0] sh;
    sh = tbl >> {row, 2'b00};
    return sh[PHASE_PINS-1:0];
  endfunction

endpackage

>>> sv/stepper_phase_sequencer_core.sv
// Four-wire stepper full-step sequencer: command decode, step state, output word.
// Depends on sps_pkg and sps_div.
//
// Usage:
//   Input words (in_valid/in_stall/in_data) are ticks (one per microsecond),
//   move commands (signed step count) or run-forward commands. Every accepted
//   word returns exactly one output word (out_valid/out_stall/out_data) with
//   coil pins, position, busy and a stepped flag.
//   Configuration: cfg_we with cfg_index 0 steps per revolution, 1 speed in
//   rpm, 2 phase table; write only while the block is idle.
// Command flow:
//   A tick, an ignored command or an unknown code needs no divide; its word
//   is in the output register on the next cycle. A move or run command runs
//   two passes through one shared bit-serial divider (minute over steps per
//   revolution, then over speed); input stays stalled until its word is
//   loaded, so no new word is taken while a command is in progress.
// Reset: synchronous, active low; registers but the command and output payload
//   go to their reset values, the coils are all low and the position is zero.
// Stall: a finished word waits in the output register; the next input word
//   is taken only once that register is free or being drained.
module stepper_phase_sequencer_core
  import sps_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sps_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sps_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV1 = 4'b0010,
    S_DIV2 = 4'b0100,
    S_FIN  = 4'b1000
  } sps_state_t;

  sps_state_t state_r, state_nxt;

  logic [CFG_W-1:0] spr_r, speed_r, tbl_r;

  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [POS_W-1:0]      rem_r, rem_nxt;
  logic                  rev_r, rev_nxt;
  logic                  run_r, run_nxt;
  logic [DIV_W-1:0]      delay_r, delay_nxt;
  logic [DIV_W-1:0]      dc_r, dc_nxt;
  logic [PHASE_PINS-1:0] pins_r, pins_nxt;

  logic [1:0]       cmd_type_r, cmd_type_nxt;
  logic [POS_W-1:0] cmd_cnt_r, cmd_cnt_nxt;

  logic     out_valid_r, out_valid_nxt;
  sps_out_t out_data_r, out_data_nxt;

  sps_div_req_t div_req;
  sps_div_rsp_t div_rsp;

  logic             in_accept, out_free, is_cmd, cmd_ok;
  logic             take_step, load_out, stepped;
  logic [DIV_W-1:0] dc_dec;
  logic [POS_W-1:0] pos_step;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign is_cmd    = (in_data.req_type == REQ_MOVE) || (in_data.req_type == REQ_RUN);
  assign cmd_ok    = (speed_r != '0) && (spr_r != '0);
  assign dc_dec    = (dc_r != '0) ? dc_r - DIV_W'(1) : dc_r;

  sps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r   <= SPR_RST;
      speed_r <= SPEED_RST;
      tbl_r   <= TABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPR:   spr_r   <= cfg_wdata;
        CFG_SPEED: speed_r <= cfg_wdata;
        CFG_TABLE: tbl_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: decode words, drive the divider, apply steps
  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    rev_nxt      = rev_r;
    run_nxt      = run_r;
    delay_nxt    = delay_r;
    dc_nxt       = dc_r;
    cmd_type_nxt = cmd_type_r;
    cmd_cnt_nxt  = cmd_cnt_r;
    take_step    = 1'b0;
    load_out     = 1'b0;
    div_req      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (is_cmd && cmd_ok) begin
            cmd_type_nxt     = in_data.req_type;
            cmd_cnt_nxt      = in_data.step_count;
            div_req.start    = 1'b1;
            div_req.dividend = US_PER_MIN;
            div_req.divisor  = spr_r;
            state_nxt        = S_DIV1;
          end else begin
            load_out = 1'b1;
            if (in_data.req_type == REQ_TICK) begin
              dc_nxt = dc_dec;
              if ((dc_dec == '0) && (run_r || (rem_r != '0))) begin
                if (speed_r == '0) begin
                  run_nxt = 1'b0;
                  rem_nxt = '0;
                end else begin
                  take_step = 1'b1;
                  if (!run_r) begin
                    rem_nxt = rem_r - POS_W'(1);
                  end
                end
              end
            end
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = speed_r;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          delay_nxt = div_rsp.quotient;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          dc_nxt    = '0;
          if (cmd_type_r == REQ_RUN) begin
            run_nxt   = 1'b1;
            rev_nxt   = 1'b0;
            rem_nxt   = '0;
            take_step = 1'b1;
          end else begin
            run_nxt = 1'b0;
            rev_nxt = cmd_cnt_r[POS_W-1];
            if (cmd_cnt_r == '0) begin
              rem_nxt = '0;
            end else begin
              take_step = 1'b1;
              // magnitude minus one: ~x for negative, x - 1 for positive
              rem_nxt = cmd_cnt_r[POS_W-1] ? ~cmd_cnt_r : cmd_cnt_r - POS_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Step: advance position, pick the coil row, reload the delay
  assign pos_step = sps_next_pos(pos_r, spr_r, rev_nxt);
  assign pos_nxt  = take_step ? pos_step : pos_r;
  assign pins_nxt = take_step ? sps_row_pins(tbl_r, pos_step[1:0]) : pins_r;
  assign stepped  = take_step;

  // Output register: load on each finished word, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load_out) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.phase_pins = pins_nxt;
      out_data_nxt.position   = pos_nxt;
      out_data_nxt.busy_res   = run_nxt || (rem_nxt != '0) ||
                                ((take_step ? delay_r : dc_nxt) != '0);
      out_data_nxt.stepped    = stepped;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      rem_r       <= '0;
      rev_r       <= 1'b0;
      run_r       <= 1'b0;
      delay_r     <= '0;
      dc_r        <= '0;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      rev_r       <= rev_nxt;
      run_r       <= run_nxt;
      delay_r     <= delay_nxt;
      dc_r        <= take_step ? delay_r : dc_nxt;
      pins_r      <= pins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and output payload hold without reset
  always_ff @(posedge clk) begin
    cmd_type_r <= cmd_type_nxt;
    cmd_cnt_r  <= cmd_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A divider result only shows up while a command waits for it
  a_div_done_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == S_DIV1) || (state_r == S_DIV2)))
    else $error("divider finished outside a command");

  // A word that needs no divide is presented on the next cycle
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !(is_cmd && cmd_ok)) |=> (out_valid && (state_r == S_IDLE)))
    else $error("direct word did not reach the output");

  // A command that finishes its divides leaves one output word behind
  a_cmd_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_free) |=> (out_valid && (state_r == S_IDLE)))
    else $error("command result was not loaded");

endmodule

>>> sv/sps_div.sv
// Restoring divider, one quotient bit per cycle, for the step delay.
// Depends on sps_pkg for widths and the request/response structs.
module sps_div
  import sps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  sps_div_req_t req,
  output sps_div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // Trial subtract of the divisor from the shifted remainder
  assign diff = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, dvs_r};
  assign ge   = !diff[DVS_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVS_W-1:0] : {rem_r[DVS_W-2:0], quo_r[DIV_W-1]};
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath holds without reset
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
